// File: hdl/bcs_pkg.sv
// Shared types and constants for the breathing-cycle stepper sequencer.
// Used by bcs_csr, bcs_core and breath_cycle_stepper_sequencer; no dependencies.
`default_nettype none

package bcs_pkg;

   localparam int STROKE_W    = 10;
   localparam int DWELL_CFG_W = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STROKE_W-1:0]    STROKE_RESET = 10'd475;
   localparam logic [DWELL_CFG_W-1:0] DWELL_RESET  = 16'd1500;

   localparam logic [CSR_INDEX_W-1:0] CSR_STROKE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOTTOM_DWELL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_DWELL    = 2'd2;

   typedef enum logic [2:0] {
      PH_STOPPED = 3'd0,
      PH_BOTTOM  = 3'd1,
      PH_RISE    = 3'd2,
      PH_DESCENT = 3'd3,
      PH_TOP     = 3'd4
   } phase_type;

   typedef struct packed {
      logic [STROKE_W-1:0]    stroke_steps;
      logic [DWELL_CFG_W-1:0] bottom_dwell_ms;
      logic [DWELL_CFG_W-1:0] top_dwell_ms;
   } cfg_type;

   typedef struct packed {
      logic run_enable;
      logic home_switch;
      logic ms_tick;
      logic step_tick;
   } req_type;

endpackage

`default_nettype wire

// File: hdl/bcs_csr.sv
// Configuration registers of the sequencer: stroke length and the two dwell times.
// Depends on bcs_pkg for the register indexes, reset values and cfg_type.
`default_nettype none

module bcs_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [bcs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bcs_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output bcs_pkg::cfg_type                    cfg
);
   import bcs_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stroke_steps    <= STROKE_RESET;
         cfg_ff.bottom_dwell_ms <= DWELL_RESET;
         cfg_ff.top_dwell_ms    <= DWELL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STROKE: begin
               cfg_ff.stroke_steps <= csr_write_data[STROKE_W-1:0];
            end
            CSR_BOTTOM_DWELL: begin
               cfg_ff.bottom_dwell_ms <= csr_write_data[DWELL_CFG_W-1:0];
            end
            CSR_TOP_DWELL: begin
               cfg_ff.top_dwell_ms <= csr_write_data[DWELL_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/bcs_core.sv
// Sequencer state and the single-pass update that one request applies to it.
// Depends on bcs_pkg for the phase codes, cfg_type and req_type.
`default_nettype none

module bcs_core #(
   parameter int POSITION_BITS = 12,
   parameter int DWELL_BITS    = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  bcs_pkg::req_type                 req,
   input  bcs_pkg::cfg_type                 cfg,
   output logic                             step_pulse,
   output logic                             direction,
   output bcs_pkg::phase_type               phase,
   output logic signed [POSITION_BITS-1:0]  position,
   output logic                             motor_running
);
   import bcs_pkg::*;

   localparam int CW = 33;
   localparam int EW = (DWELL_BITS > DWELL_CFG_W) ? DWELL_BITS : DWELL_CFG_W;
   localparam logic [DWELL_BITS-1:0]    EL_MAX = {DWELL_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] P_MAX  = {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam logic [POSITION_BITS-1:0] P_MIN  = {1'b1, {(POSITION_BITS-1){1'b0}}};

   phase_type                phase_ff, phase_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_step;
   logic [DWELL_BITS-1:0]    elapsed_ff, elapsed_in;
   logic                     dir_ff, dir_in;
   logic                     enabled_ff, enabled_in;
   logic                     rise_done_ff, rise_done_in;
   logic                     fall_done_ff, fall_done_in;
   logic                     pulse;

   always_comb begin
      elapsed_in   = elapsed_ff;
      pos_in       = pos_ff;
      pos_step     = pos_ff;
      dir_in       = dir_ff;
      enabled_in   = enabled_ff;
      rise_done_in = rise_done_ff;
      fall_done_in = fall_done_ff;
      phase_in     = phase_ff;
      pulse        = 1'b0;

      if (req.ms_tick && (elapsed_ff != EL_MAX)) begin
         elapsed_in = elapsed_ff + DWELL_BITS'(1);
      end

      if (req.step_tick && enabled_ff) begin
         pulse = 1'b1;
         if (dir_ff) begin
            if (pos_ff != P_MAX) begin
               pos_step = pos_ff + POSITION_BITS'(1);
            end
            if ($signed(CW'($signed(pos_step))) >=
                $signed(CW'(cfg.stroke_steps))) begin
               rise_done_in = 1'b1;
               enabled_in   = 1'b0;
            end
         end else begin
            if (pos_ff != P_MIN) begin
               pos_step = pos_ff - POSITION_BITS'(1);
            end
            if (pos_step[POSITION_BITS-1] || (pos_step == '0)) begin
               fall_done_in = 1'b1;
               enabled_in   = 1'b0;
            end
         end
      end
      pos_in = pos_step;

      if (!req.home_switch) begin
         pos_in = '0;
      end

      case (phase_ff)
         PH_BOTTOM: begin
            if (EW'(elapsed_in) >= EW'(cfg.bottom_dwell_ms)) begin
               dir_in     = 1'b1;
               enabled_in = 1'b1;
               phase_in   = PH_RISE;
            end
         end
         PH_RISE: begin
            if (rise_done_in) begin
               rise_done_in = 1'b0;
               elapsed_in   = '0;
               phase_in     = PH_TOP;
            end
         end
         PH_TOP: begin
            if (EW'(elapsed_in) >= EW'(cfg.top_dwell_ms)) begin
               dir_in     = 1'b0;
               enabled_in = 1'b1;
               phase_in   = PH_DESCENT;
            end
         end
         PH_DESCENT: begin
            if (fall_done_in) begin
               fall_done_in = 1'b0;
               elapsed_in   = '0;
               phase_in     = PH_BOTTOM;
            end
         end
         default: begin
            phase_in = PH_STOPPED;
            if (req.run_enable) begin
               elapsed_in = '0;
               phase_in   = PH_BOTTOM;
            end
         end
      endcase

      if (!req.run_enable && (phase_in != PH_STOPPED)) begin
         enabled_in = 1'b0;
         phase_in   = PH_STOPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STOPPED;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         dir_ff       <= 1'b0;
         enabled_ff   <= 1'b0;
         rise_done_ff <= 1'b0;
         fall_done_ff <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
         dir_ff       <= dir_in;
         enabled_ff   <= enabled_in;
         rise_done_ff <= rise_done_in;
         fall_done_ff <= fall_done_in;
      end
   end

   assign step_pulse    = pulse;
   assign direction     = dir_in;
   assign phase         = phase_in;
   assign position      = $signed(pos_in);
   assign motor_running = enabled_in;

endmodule

`default_nettype wire

// File: hdl/breath_cycle_stepper_sequencer.sv
// Breathing-cycle stepper sequencer: stopped, bottom dwell, rise, top dwell, descent.
// From request acceptance to a valid result there is one input register, then the
// state update and the result register; the update waits while the result is stalled.
// Throughput is one request per cycle unless rsp_ready stalls; the input register and
// the result register decouple the two sides. Reset clears all sequencer state and loads
// the default stroke and dwell registers. Depends on bcs_pkg, bcs_csr and bcs_core.
`default_nettype none

module breath_cycle_stepper_sequencer #(
   parameter int POSITION_BITS = 12,
   parameter int DWELL_BITS    = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_run_enable,
   input  wire                              req_home_switch,
   input  wire                              req_ms_tick,
   input  wire                              req_step_tick,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_step_pulse,
   output logic                             rsp_direction,
   output logic [2:0]                       rsp_phase,
   output logic signed [POSITION_BITS-1:0]  rsp_position,
   output logic                             rsp_motor_running,
   input  wire                              csr_write_enable,
   input  wire  [bcs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [bcs_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bcs_pkg::*;

   cfg_type                          cfg;
   req_type                          req_ff;
   logic                             in_valid_ff, in_valid_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_open;
   logic                             advance;
   logic                             nx_pulse, nx_dir, nx_running;
   phase_type                        nx_phase;
   logic signed [POSITION_BITS-1:0]  nx_position;
   logic                             pulse_ff, dir_ff, running_ff;
   phase_type                        phase_ff;
   logic signed [POSITION_BITS-1:0]  position_ff;

   bcs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bcs_core #(
      .POSITION_BITS (POSITION_BITS),
      .DWELL_BITS    (DWELL_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req           (req_ff),
      .cfg           (cfg),
      .step_pulse    (nx_pulse),
      .direction     (nx_dir),
      .phase         (nx_phase),
      .position      (nx_position),
      .motor_running (nx_running)
   );

   assign out_open  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.run_enable  <= req_run_enable;
         req_ff.home_switch <= req_home_switch;
         req_ff.ms_tick     <= req_ms_tick;
         req_ff.step_tick   <= req_step_tick;
      end
      if (advance) begin
         pulse_ff    <= nx_pulse;
         dir_ff      <= nx_dir;
         phase_ff    <= nx_phase;
         position_ff <= nx_position;
         running_ff  <= nx_running;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_step_pulse    = pulse_ff;
   assign rsp_direction     = dir_ff;
   assign rsp_phase         = phase_ff;
   assign rsp_position      = position_ff;
   assign rsp_motor_running = running_ff;

endmodule

`default_nettype wire

// File: tb/sv/breath_cycle_stepper_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for breath_cycle_stepper_sequencer: directed, extreme and random
// requests under varied idling and back-pressure. Depends on bcs_pkg and the sequencer RTL.

module breath_cycle_stepper_sequencer_tb;
   import bcs_pkg::*;

   localparam int POS_BITS    = 12;
   localparam int POS_MAX     = 2047;
   localparam int POS_MIN     = -2048;
   localparam int ELAPSED_MAX = 65535;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      logic                step_pulse;
      logic                direction;
      phase_type           phase;
      logic [POS_BITS-1:0] position;
      logic                motor_running;
   } stepper_output_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_run_enable = 1'b0;
   logic req_home_switch = 1'b1;
   logic req_ms_tick = 1'b0;
   logic req_step_tick = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_step_pulse;
   logic rsp_direction;
   logic [2:0] rsp_phase;
   logic signed [POS_BITS-1:0] rsp_position;
   logic rsp_motor_running;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_STROKE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   cfg_type   cycle_cfg;
   phase_type cycle_phase;
   int        step_pos;
   int        elapsed_ms;
   logic      motor_dir;
   logic      motor_on;
   logic      rise_done;
   logic      fall_done;

   stepper_output_type pending_outputs[$];
   int error_count = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_off = 1'b0;

   breath_cycle_stepper_sequencer #(
      .POSITION_BITS(POS_BITS),
      .DWELL_BITS(16)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_run_enable(req_run_enable),
      .req_home_switch(req_home_switch),
      .req_ms_tick(req_ms_tick),
      .req_step_tick(req_step_tick),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_step_pulse(rsp_step_pulse),
      .rsp_direction(rsp_direction),
      .rsp_phase(rsp_phase),
      .rsp_position(rsp_position),
      .rsp_motor_running(rsp_motor_running),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic void clear_sequencer();
      cycle_cfg.stroke_steps    = STROKE_RESET;
      cycle_cfg.bottom_dwell_ms = DWELL_RESET;
      cycle_cfg.top_dwell_ms    = DWELL_RESET;
      cycle_phase = PH_STOPPED;
      step_pos    = 0;
      elapsed_ms  = 0;
      motor_dir   = 1'b0;
      motor_on    = 1'b0;
      rise_done   = 1'b0;
      fall_done   = 1'b0;
   endfunction

   function automatic stepper_output_type advance_breath_cycle(req_type r);
      stepper_output_type o;
      o.step_pulse = 1'b0;
      if (r.ms_tick && elapsed_ms < ELAPSED_MAX) elapsed_ms++;
      if (r.step_tick && motor_on) begin
         o.step_pulse = 1'b1;
         if (motor_dir) begin
            if (step_pos < POS_MAX) step_pos++;
            if (step_pos >= int'(cycle_cfg.stroke_steps)) begin
               rise_done = 1'b1;
               motor_on  = 1'b0;
            end
         end else begin
            if (step_pos > POS_MIN) step_pos--;
            if (step_pos <= 0) begin
               fall_done = 1'b1;
               motor_on  = 1'b0;
            end
         end
      end
      if (!r.home_switch) step_pos = 0;
      case (cycle_phase)
         PH_BOTTOM: begin
            if (elapsed_ms >= int'(cycle_cfg.bottom_dwell_ms)) begin
               motor_dir   = 1'b1;
               motor_on    = 1'b1;
               cycle_phase = PH_RISE;
            end
         end
         PH_RISE: begin
            if (rise_done) begin
               rise_done   = 1'b0;
               elapsed_ms  = 0;
               cycle_phase = PH_TOP;
            end
         end
         PH_TOP: begin
            if (elapsed_ms >= int'(cycle_cfg.top_dwell_ms)) begin
               motor_dir   = 1'b0;
               motor_on    = 1'b1;
               cycle_phase = PH_DESCENT;
            end
         end
         PH_DESCENT: begin
            if (fall_done) begin
               fall_done   = 1'b0;
               elapsed_ms  = 0;
               cycle_phase = PH_BOTTOM;
            end
         end
         default: begin
            cycle_phase = PH_STOPPED;
            if (r.run_enable) begin
               elapsed_ms  = 0;
               cycle_phase = PH_BOTTOM;
            end
         end
      endcase
      if (!r.run_enable && cycle_phase != PH_STOPPED) begin
         motor_on    = 1'b0;
         cycle_phase = PH_STOPPED;
      end
      o.direction     = motor_dir;
      o.phase         = cycle_phase;
      o.position      = POS_BITS'(step_pos);
      o.motor_running = motor_on;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [POS_BITS-1:0] expv,
                              input logic [POS_BITS-1:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0d, got %0d", name, $signed(expv), $signed(actv));
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      stepper_output_type want;
      if (reset) begin
         clear_sequencer();
         pending_outputs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $error("result arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_outputs.pop_front();
               check_field("step_pulse", POS_BITS'(want.step_pulse),
                           POS_BITS'(rsp_step_pulse));
               check_field("direction", POS_BITS'(want.direction),
                           POS_BITS'(rsp_direction));
               check_field("phase", POS_BITS'(want.phase), POS_BITS'(rsp_phase));
               check_field("position", want.position, rsp_position);
               check_field("motor_running", POS_BITS'(want.motor_running),
                           POS_BITS'(rsp_motor_running));
               results_checked++;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STROKE:       cycle_cfg.stroke_steps    = csr_write_data[STROKE_W-1:0];
               CSR_BOTTOM_DWELL: cycle_cfg.bottom_dwell_ms = csr_write_data;
               CSR_TOP_DWELL:    cycle_cfg.top_dwell_ms    = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_outputs.push_back(advance_breath_cycle(
               '{req_run_enable, req_home_switch, req_ms_tick, req_step_tick}));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_run_enable  <= r.run_enable;
      req_home_switch <= r.home_switch;
      req_ms_tick     <= r.ms_tick;
      req_step_tick   <= r.step_tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic program_config(input logic [STROKE_W-1:0] stroke,
                                 input logic [DWELL_CFG_W-1:0] bottom,
                                 input logic [DWELL_CFG_W-1:0] top);
      wait_drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STROKE;
      csr_write_data   <= {6'($urandom_range(0, 63)), stroke};
      @(posedge clock);
      csr_index      <= CSR_BOTTOM_DWELL;
      csr_write_data <= bottom;
      @(posedge clock);
      csr_index      <= CSR_TOP_DWELL;
      csr_write_data <= top;
      @(posedge clock);
      csr_index      <= CSR_UNUSED_INDEX;
      csr_write_data <= CSR_DATA_W'($urandom_range(0, 65535));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(0, 9) == 0) begin
         r = 4'($urandom_range(0, 15));
      end else begin
         r.run_enable  = $urandom_range(0, 99) >= 3;
         r.home_switch = $urandom_range(0, 99) >= 4;
         r.ms_tick     = 1'($urandom_range(0, 1));
         r.step_tick   = 1'($urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic program_random_config();
      logic [STROKE_W-1:0] stroke;
      stroke = ($urandom_range(0, 4) == 0) ? STROKE_W'($urandom_range(16, 60)) :
                                             STROKE_W'($urandom_range(0, 15));
      program_config(stroke, DWELL_CFG_W'($urandom_range(0, 8)),
                     DWELL_CFG_W'($urandom_range(0, 8)));
   endtask

   task automatic test_default_registers();
      repeat (100) send_request(4'b1111);
      send_request(4'b0100);
   endtask

   task automatic test_directed_cases();
      // Each code is {run, home, ms, step}.
      req_type script[22] = '{
         4'b0111, 4'b1100, 4'b1110, 4'b1101, 4'b1101, 4'b1110, 4'b1101, 4'b1000,
         4'b1101, 4'b1111, 4'b1001, 4'b1101, 4'b0101, 4'b1110, 4'b0110, 4'b1100,
         4'b1110, 4'b1101, 4'b1110, 4'b1101, 4'b0101, 4'b0000};
      program_config(10'd2, 16'd1, 16'd1);
      foreach (script[i]) send_request(script[i]);
   endtask

   task automatic test_dwell_extremes();
      program_config(10'd0, 16'd0, 16'd0);
      repeat (30) send_request(4'b1101);
      repeat (30) send_request(4'b1111);
      program_config(10'd0, 16'hFFFF, 16'hFFFF);
      repeat (30) send_request(4'b1111);
      send_request(4'b0100);
   endtask

   task automatic test_full_stroke();
      program_config(10'd1023, 16'd0, 16'd0);
      repeat (100) send_request(4'b1101);
      send_request(4'b0100);
   endtask

   task automatic test_backpressure();
      program_random_config();
      fork
         repeat (120) send_request(random_request());
         begin
            hold_off <= 1'b1;
            repeat (60) @(posedge clock);
            hold_off <= 1'b0;
         end
      join
      wait_drain();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) program_random_config();
         send_request(random_request());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_directed_cases();
      test_dwell_extremes();
      test_full_stroke();
      test_backpressure();
      test_random_traffic(0, 0, 200);
      test_random_traffic(79, 0, 200);
      test_random_traffic(0, 79, 200);
      test_random_traffic(35, 35, 200);
      wait_drain();
      repeat (4) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         $error("%0d expected results never arrived", pending_outputs.size());
         error_count++;
      end
      $display("Sent %0d requests: default and extreme registers, directed cases, random mixes.",
               requests_sent);
      $display("Checked %0d results across four idle/stall mixes and a receiver hold-off.",
               results_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
